// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is high.
`define MUR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Concurrent check that also runs through reset.
`define MUR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/mur_pkg.sv =====
`timescale 1ns / 1ps

package mur_pkg;

  localparam int SENSORS      = 8;
  localparam int TICKS_PER_MS = 1000;

  localparam int ECHO_W     = 8;
  localparam int QIDX_W     = 3;
  localparam int MM_W       = 14;
  localparam int TIME_W     = 16;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int SENS_W     = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int CNT_W      = $clog2(SENSORS + 1);
  localparam int SUB_W      = (TICKS_PER_MS > 1) ? $clog2(TICKS_PER_MS) : 1;

  // 0.1715 mm per microsecond (half the speed of sound) in unsigned Q0.16.
  localparam logic [MM_W-1:0]   MM_PER_US_Q16   = 14'd11239;
  localparam logic [TIME_W-1:0] TRIG_LOW_TICKS  = 16'd2;
  localparam logic [TIME_W-1:0] TRIG_HIGH_TICKS = 16'd10;

  localparam logic [COUNT_W-1:0] RST_SENSOR_COUNT  = 4'd8;
  localparam logic [TIME_W-1:0]  RST_READ_INTERVAL = 16'd60;
  localparam logic [TIME_W-1:0]  RST_ECHO_TIMEOUT  = 16'd30000;
  localparam logic [MM_W-1:0]    RST_BELOW_THRESH  = 14'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENSOR_COUNT    = 4'd0,
    REG_READ_INTERVAL   = 4'd1,
    REG_ECHO_TIMEOUT    = 4'd2,
    REG_BELOW_THRESHOLD = 4'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TRIG_LOW,
    PH_TRIG_HIGH,
    PH_WAIT_LOW,
    PH_WAIT_HIGH,
    PH_MEASURE
  } phase_t;

  typedef struct packed {
    logic [COUNT_W-1:0] sensor_count;
    logic [TIME_W-1:0]  read_interval_ms;
    logic [TIME_W-1:0]  echo_timeout_us;
    logic [MM_W-1:0]    below_threshold_mm;
  } cfg_t;

  typedef struct packed {
    logic [ECHO_W-1:0] echo_lines;
    logic [QIDX_W-1:0] query_index;
  } tick_t;

  typedef struct packed {
    logic              trigger_level;
    logic              reading_done;
    logic [QIDX_W-1:0] reading_sensor;
    logic [MM_W-1:0]   reading_mm;
    logic [MM_W-1:0]   query_mm;
    logic              query_valid;
    logic [MM_W-1:0]   nearest_mm;
    logic              nearest_valid;
    logic              all_below;
  } result_t;

  // What the sequencer reports for one tick.
  typedef struct packed {
    logic              trig;
    logic              done;
    logic [QIDX_W-1:0] sensor;
    logic [MM_W-1:0]   mm;
  } reading_t;

  // What the distance store reports for one tick.
  typedef struct packed {
    logic [MM_W-1:0] query_mm;
    logic            query_valid;
    logic [MM_W-1:0] nearest_mm;
    logic            nearest_valid;
    logic            all_below;
  } query_t;

  // Number of sensors scanned: zero acts as one, large values clamp.
  function automatic logic [CNT_W-1:0] active_count(input logic [COUNT_W-1:0] n);
    logic [CNT_W-1:0] r;
    if (n == '0) begin
      r = CNT_W'(1);
    end else if (int'(n) > SENSORS) begin
      r = CNT_W'(SENSORS);
    end else begin
      r = CNT_W'(n);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/mur_if.sv =====
`timescale 1ns / 1ps

interface mur_cfg_if import mur_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface mur_tick_if import mur_pkg::*; ();
  logic  valid;
  logic  ready;
  tick_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mur_result_if import mur_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/mur_sequencer.sv =====
`timescale 1ns / 1ps

module mur_sequencer import mur_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [ECHO_W-1:0] echo_lines,
  input  cfg_t              cfg_regs,
  output reading_t          rd
);

  phase_t              phase, phase_next, phase_cur;
  logic [TIME_W-1:0]   timer, timer_next;
  logic [TIME_W-1:0]   width, width_next;
  logic [TIME_W-1:0]   ms, ms_next;
  logic [SUB_W-1:0]    sub_ms, sub_ms_next;
  logic [SENS_W-1:0]   cur, cur_next;
  logic [SUB_W:0]      sub_inc;
  logic [CNT_W-1:0]    n_act, cur_inc;
  logic                line, waiting, advance;
  logic [TIME_W+MM_W-1:0] product;

  assign n_act   = active_count(cfg_regs.sensor_count);
  assign product = (TIME_W+MM_W)'(width) * (TIME_W+MM_W)'(MM_PER_US_Q16);

  always_comb begin
    phase_next  = phase;
    timer_next  = timer;
    width_next  = width;
    ms_next     = ms;
    sub_ms_next = sub_ms;
    cur_next    = cur;
    rd          = '0;
    waiting     = 1'b0;
    advance     = 1'b0;
    line        = 1'b0;
    cur_inc     = CNT_W'(cur) + CNT_W'(1);

    // Millisecond time base; the count since the last start saturates.
    sub_inc = {1'b0, sub_ms} + (SUB_W+1)'(1);
    if (sub_inc >= (SUB_W+1)'(TICKS_PER_MS)) begin
      sub_ms_next = '0;
      if (ms != '1) begin
        ms_next = ms + TIME_W'(1);
      end
    end else begin
      sub_ms_next = sub_inc[SUB_W-1:0];
    end

    if (phase == PH_IDLE && ms_next >= cfg_regs.read_interval_ms) begin
      ms_next     = '0;
      sub_ms_next = '0;
      phase_next  = PH_TRIG_LOW;
      timer_next  = '0;
    end
    phase_cur = phase_next;

    // Sensors without an echo line read low.
    for (int i = 0; i < ECHO_W; i++) begin
      if (int'(cur) == i) begin
        line = echo_lines[i];
      end
    end

    case (phase_cur)
      PH_TRIG_LOW: begin
        timer_next = timer_next + TIME_W'(1);
        if (timer_next >= TRIG_LOW_TICKS) begin
          phase_next = PH_TRIG_HIGH;
          timer_next = '0;
        end
      end
      PH_TRIG_HIGH: begin
        rd.trig    = 1'b1;
        timer_next = timer_next + TIME_W'(1);
        if (timer_next >= TRIG_HIGH_TICKS) begin
          phase_next = PH_WAIT_LOW;
          timer_next = '0;
        end
      end
      PH_WAIT_LOW: begin
        if (!line) begin
          phase_next = PH_WAIT_HIGH;
        end
        waiting = 1'b1;
      end
      PH_WAIT_HIGH: begin
        if (line) begin
          phase_next = PH_MEASURE;
          width_next = TIME_W'(1);
        end
        waiting = 1'b1;
      end
      PH_MEASURE: begin
        if (line) begin
          if (width != '1) begin
            width_next = width + TIME_W'(1);
          end
          waiting = 1'b1;
        end else begin
          rd.done   = 1'b1;
          rd.sensor = QIDX_W'(cur);
          rd.mm     = product[TIME_W +: MM_W];
          advance   = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    if (waiting) begin
      if (timer_next != '1) begin
        timer_next = timer_next + TIME_W'(1);
      end
      if (timer_next >= cfg_regs.echo_timeout_us) begin
        advance = 1'b1;
      end
    end

    if (advance) begin
      phase_next = PH_IDLE;
      if (cur_inc >= n_act) begin
        cur_next = '0;
      end else begin
        cur_next = cur_inc[SENS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      timer  <= '0;
      width  <= '0;
      ms     <= RST_READ_INTERVAL;
      sub_ms <= '0;
      cur    <= '0;
    end else if (step) begin
      phase  <= phase_next;
      timer  <= timer_next;
      width  <= width_next;
      ms     <= ms_next;
      sub_ms <= sub_ms_next;
      cur    <= cur_next;
    end
  end

endmodule

// ===== rtl/core/mur_store.sv =====
`timescale 1ns / 1ps

module mur_store import mur_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  reading_t          wr,
  input  logic [QIDX_W-1:0] query_index,
  input  cfg_t              cfg_regs,
  output query_t            qr
);

  logic [MM_W-1:0]    dist_mem [SENSORS];
  logic [SENSORS-1:0] valid_bits;
  logic [CNT_W-1:0]   n_act;

  assign n_act = active_count(cfg_regs.sensor_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (we) begin
      for (int i = 0; i < SENSORS; i++) begin
        if (int'(wr.sensor) == i) begin
          valid_bits[i] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < SENSORS; i++) begin
        if (int'(wr.sensor) == i) begin
          dist_mem[i] <= wr.mm;
        end
      end
    end
  end

  // Entries without a reading are ignored, so the array needs no reset.
  always_comb begin
    qr           = '0;
    qr.all_below = 1'b1;
    for (int i = 0; i < SENSORS; i++) begin
      if (CNT_W'(i) < n_act) begin
        if (valid_bits[i]) begin
          if (!qr.nearest_valid || dist_mem[i] < qr.nearest_mm) begin
            qr.nearest_mm = dist_mem[i];
          end
          qr.nearest_valid = 1'b1;
          if (dist_mem[i] > cfg_regs.below_threshold_mm) begin
            qr.all_below = 1'b0;
          end
          if (int'(query_index) == i) begin
            qr.query_valid = 1'b1;
            qr.query_mm    = dist_mem[i];
          end
        end else begin
          qr.all_below = 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/core/multi_ultrasonic_ranger.sv =====
`timescale 1ns / 1ps

// Round-robin ranger for up to eight ultrasonic sensors that share one trigger line.
// Every transfer on the tick channel is one microsecond: it carries the sampled echo
// lines and a query index, and it produces exactly one transfer on the result channel.
// At the start of each read interval (measured start to start, in milliseconds) the
// trigger is held low for 2 ticks and high for 10, then the current sensor's echo is
// timed: wait for low, wait for high, then count the high width; the stored distance
// is width * 11239 >> 16 mm. If the echo timeout runs out first, nothing is stored.
// Either way the scan moves on to the next sensor. Each result carries the trigger
// level, any reading stored on that tick, the stored distance of the queried sensor,
// the nearest distance and the all-below flag, all as they stand after that tick.
// The block takes one tick per clock cycle while the result channel keeps up; the
// sequencer's counters update on each accepted tick, its echo multiply is
// combinational, and each result passes the tick stage before it is offered. The tick
// stage and the result register form a two-entry pipeline; while a result waits,
// one more tick can be taken into the stage before the tick channel stalls.
// Configuration writes are taken in any cycle; change them only while no result is
// outstanding. No clearing pass is needed after reset.
module multi_ultrasonic_ranger import mur_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  mur_cfg_if.sink      cfg,
  mur_tick_if.sink     tick,
  mur_result_if.source result
);

  cfg_t              cfg_regs;
  reading_t          rd;
  query_t            qr;
  reading_t          stage_rd;
  logic [QIDX_W-1:0] stage_query;
  logic              stage_valid;
  result_t           out_data;
  logic              out_valid;
  logic              out_free;
  logic              accept;
  logic              stage_move;

  // The result register can load when it is empty or its result is taken now.
  assign out_free   = !out_valid || result.ready;
  assign tick.ready = !stage_valid || out_free;
  assign accept     = tick.valid && tick.ready;
  assign stage_move = stage_valid && out_free;
  assign cfg.ready  = 1'b1;

  assign result.valid = out_valid;
  assign result.data  = out_data;

  // The sequencer advances exactly once per accepted tick.
  mur_sequencer u_seq (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .echo_lines (tick.data.echo_lines),
    .cfg_regs   (cfg_regs),
    .rd         (rd)
  );

  // The store is written on the same edge that moves the tick into the stage,
  // so while the tick sits in the stage the store shows the state after it.
  // A new tick is only accepted when the staged one leaves in the same edge.
  mur_store u_store (
    .clk         (clk),
    .rst         (rst),
    .we          (accept && rd.done),
    .wr          (rd),
    .query_index (stage_query),
    .cfg_regs    (cfg_regs),
    .qr          (qr)
  );

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.sensor_count       <= RST_SENSOR_COUNT;
      cfg_regs.read_interval_ms   <= RST_READ_INTERVAL;
      cfg_regs.echo_timeout_us    <= RST_ECHO_TIMEOUT;
      cfg_regs.below_threshold_mm <= RST_BELOW_THRESH;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_SENSOR_COUNT:    cfg_regs.sensor_count       <= cfg.data[COUNT_W-1:0];
        REG_READ_INTERVAL:   cfg_regs.read_interval_ms   <= cfg.data[TIME_W-1:0];
        REG_ECHO_TIMEOUT:    cfg_regs.echo_timeout_us    <= cfg.data[TIME_W-1:0];
        REG_BELOW_THRESHOLD: cfg_regs.below_threshold_mm <= cfg.data[MM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        stage_valid <= 1'b1;
      end else if (stage_move) begin
        stage_valid <= 1'b0;
      end
      if (stage_move) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      stage_rd    <= rd;
      stage_query <= tick.data.query_index;
    end
    if (stage_move) begin
      out_data.trigger_level  <= stage_rd.trig;
      out_data.reading_done   <= stage_rd.done;
      out_data.reading_sensor <= stage_rd.sensor;
      out_data.reading_mm     <= stage_rd.mm;
      out_data.query_mm       <= qr.query_mm;
      out_data.query_valid    <= qr.query_valid;
      out_data.nearest_mm     <= qr.nearest_mm;
      out_data.nearest_valid  <= qr.nearest_valid;
      out_data.all_below      <= qr.all_below;
    end
  end

endmodule

// ===== rtl/core/mur_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mur_checker import mur_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    res_valid,
  input logic    res_ready,
  input result_t res_data
);

  `MUR_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !res_valid, "result valid right after reset")

  `MUR_ASSERT(a_stall_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res_data), "stalled result changed")

  `MUR_ASSERT(a_done_shape, clk, rst, res_valid && res_data.reading_done |-> !res_data.trigger_level, "new reading with trigger high")

  `MUR_ASSERT(a_nearest_le_query, clk, rst, res_valid && res_data.query_valid |-> res_data.nearest_valid && (res_data.nearest_mm <= res_data.query_mm), "nearest distance above queried distance")

endmodule

bind multi_ultrasonic_ranger mur_checker u_mur_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_data  (result.data)
);

// ===== tb/ranging_checker.sv =====
`timescale 1ns / 1ps

module ranging_checker import mur_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  mur_cfg_if    cfg_mon,
  mur_tick_if   tick_mon,
  mur_result_if res_mon,
  output int    mismatches,
  output int    outstanding
);

  localparam int unsigned TRIG_LOW_US    = 2;
  localparam int unsigned TRIG_HIGH_US   = 10;
  localparam int unsigned HALF_SOUND_Q16 = 11239;
  localparam int unsigned COUNT_MAX      = 16'hFFFF;

  // Register copies as the block should hold them.
  logic [COUNT_W-1:0] scan_setting;
  logic [TIME_W-1:0]  interval_ms;
  logic [TIME_W-1:0]  timeout_us;
  logic [MM_W-1:0]    limit_mm;

  // Sequencer and distance store copies.
  phase_t             step;
  int unsigned        step_ticks;
  int unsigned        pulse_us;
  int unsigned        usec_in_ms;
  int unsigned        ms_elapsed;
  int unsigned        sensor_sel;
  logic [MM_W-1:0]    dist_mm [SENSORS];
  logic [SENSORS-1:0] has_dist;

  result_t            tick_outcomes [$];

  function automatic int unsigned scanned_sensors();
    int unsigned n;
    n = scan_setting;
    if (n == 0) n = 1;
    if (n > SENSORS) n = SENSORS;
    return n;
  endfunction

  function automatic void move_to_next_sensor();
    sensor_sel = (sensor_sel + 1 >= scanned_sensors()) ? 0 : sensor_sel + 1;
    step = PH_IDLE;
  endfunction

  // Advances the ranger by one microsecond and returns what it reports for it.
  function automatic result_t range_one_tick(input tick_t t);
    result_t     r;
    logic        line;
    bit          timing;
    int unsigned n;
    int unsigned i;
    r = '0;
    timing = 1'b0;

    usec_in_ms++;
    if (usec_in_ms >= TICKS_PER_MS) begin
      usec_in_ms = 0;
      if (ms_elapsed < COUNT_MAX) ms_elapsed++;
    end
    if (step == PH_IDLE && ms_elapsed >= interval_ms) begin
      ms_elapsed = 0;
      usec_in_ms = 0;
      step = PH_TRIG_LOW;
      step_ticks = 0;
    end

    line = t.echo_lines[sensor_sel];
    case (step)
      PH_TRIG_LOW: begin
        step_ticks++;
        if (step_ticks >= TRIG_LOW_US) begin
          step = PH_TRIG_HIGH;
          step_ticks = 0;
        end
      end
      PH_TRIG_HIGH: begin
        r.trigger_level = 1'b1;
        step_ticks++;
        if (step_ticks >= TRIG_HIGH_US) begin
          step = PH_WAIT_LOW;
          step_ticks = 0;
        end
      end
      PH_WAIT_LOW: begin
        if (!line) step = PH_WAIT_HIGH;
        timing = 1'b1;
      end
      PH_WAIT_HIGH: begin
        if (line) begin
          step = PH_MEASURE;
          pulse_us = 1;
        end
        timing = 1'b1;
      end
      PH_MEASURE: begin
        if (line) begin
          if (pulse_us < COUNT_MAX) pulse_us++;
          timing = 1'b1;
        end else begin
          r.reading_done   = 1'b1;
          r.reading_sensor = QIDX_W'(sensor_sel);
          r.reading_mm     = MM_W'((pulse_us * HALF_SOUND_Q16) >> 16);
          dist_mm[sensor_sel]  = r.reading_mm;
          has_dist[sensor_sel] = 1'b1;
          move_to_next_sensor();
        end
      end
      default: begin
        step = PH_IDLE;
      end
    endcase

    if (timing) begin
      if (step_ticks < COUNT_MAX) step_ticks++;
      if (step_ticks >= timeout_us) move_to_next_sensor();
    end

    n = scanned_sensors();
    if (t.query_index < n && has_dist[t.query_index]) begin
      r.query_valid = 1'b1;
      r.query_mm    = dist_mm[t.query_index];
    end
    r.all_below = 1'b1;
    for (i = 0; i < n; i++) begin
      if (has_dist[i]) begin
        if (!r.nearest_valid || dist_mm[i] < r.nearest_mm) r.nearest_mm = dist_mm[i];
        r.nearest_valid = 1'b1;
        if (dist_mm[i] > limit_mm) r.all_below = 1'b0;
      end else begin
        r.all_below = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      scan_setting = RST_SENSOR_COUNT;
      interval_ms  = RST_READ_INTERVAL;
      timeout_us   = RST_ECHO_TIMEOUT;
      limit_mm     = RST_BELOW_THRESH;
      step         = PH_IDLE;
      step_ticks   = 0;
      pulse_us     = 0;
      usec_in_ms   = 0;
      ms_elapsed   = RST_READ_INTERVAL;
      sensor_sel   = 0;
      has_dist     = '0;
      for (int s = 0; s < SENSORS; s++) dist_mm[s] = '0;
      tick_outcomes.delete();
      mismatches   = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_SENSOR_COUNT:    scan_setting = cfg_mon.data[COUNT_W-1:0];
          REG_READ_INTERVAL:   interval_ms  = cfg_mon.data[TIME_W-1:0];
          REG_ECHO_TIMEOUT:    timeout_us   = cfg_mon.data[TIME_W-1:0];
          REG_BELOW_THRESHOLD: limit_mm     = cfg_mon.data[MM_W-1:0];
          default: ;
        endcase
      end
      // Results are matched before this edge's tick is predicted: a result
      // can never belong to a tick accepted at the same edge.
      if (res_mon.valid && res_mon.ready) begin
        if (tick_outcomes.size() == 0) begin
          $display("%0t: result transfer with no tick outstanding, actual %h",
                   $time, res_mon.data);
          mismatches++;
        end else begin
          want = tick_outcomes.pop_front();
          check_field("trigger_level", want.trigger_level, res_mon.data.trigger_level);
          check_field("reading_done", want.reading_done, res_mon.data.reading_done);
          check_field("reading_sensor", want.reading_sensor, res_mon.data.reading_sensor);
          check_field("reading_mm", want.reading_mm, res_mon.data.reading_mm);
          check_field("query_mm", want.query_mm, res_mon.data.query_mm);
          check_field("query_valid", want.query_valid, res_mon.data.query_valid);
          check_field("nearest_mm", want.nearest_mm, res_mon.data.nearest_mm);
          check_field("nearest_valid", want.nearest_valid, res_mon.data.nearest_valid);
          check_field("all_below", want.all_below, res_mon.data.all_below);
        end
      end
      if (tick_mon.valid && tick_mon.ready) begin
        tick_outcomes.push_back(range_one_tick(tick_mon.data));
      end
    end
    outstanding = tick_outcomes.size();
  end

endmodule

// ===== tb/multi_ultrasonic_ranger_tb.sv =====
`timescale 1ns / 1ps

module multi_ultrasonic_ranger_tb;
  import mur_pkg::*;

  logic clk;
  logic rst = 1'b1;
  int   mismatches;
  int   outstanding;

  // When set, both the tick sender and the result receiver run without gaps.
  bit   pace_quiet;

  // Echo waveform generator: every line alternates between low and high
  // stretches whose lengths are drawn from the current scene's spans.
  logic [ECHO_W-1:0] line_level;
  int unsigned       line_left [ECHO_W];
  int unsigned       low_span;
  int unsigned       high_span;
  bit                glitches;

  mur_cfg_if    cfg_bus ();
  mur_tick_if   tick_bus ();
  mur_result_if res_bus ();

  multi_ultrasonic_ranger dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_bus),
    .tick(tick_bus),
    .result(res_bus)
  );

  ranging_checker ranging_chk (
    .clk(clk),
    .rst(rst),
    .cfg_mon(cfg_bus),
    .tick_mon(tick_bus),
    .res_mon(res_bus),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net for a hung handshake. A correct run with the worst gaps on
  // both sides ends far earlier than this.
  initial begin
    #100_000_000;
    $display("Run timed out at %0t with %0d results outstanding", $time, outstanding);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int unsigned pick_gap();
    return pace_quiet ? 0 : $urandom_range(0, 5);
  endfunction

  // Produces the echo lines for the next microsecond. With glitches enabled a
  // single line is occasionally flipped for one tick, which breaks pulses
  // apart and produces spurious edges.
  function automatic logic [ECHO_W-1:0] shape_echo();
    logic [ECHO_W-1:0] e;
    int unsigned       b;
    for (b = 0; b < ECHO_W; b++) begin
      if (line_left[b] == 0) begin
        line_level[b] = ~line_level[b];
        line_left[b]  = line_level[b] ? $urandom_range(1, high_span)
                                      : $urandom_range(1, low_span);
      end
      line_left[b]--;
    end
    e = line_level;
    if (glitches && $urandom_range(0, 63) == 0) begin
      b = $urandom_range(0, ECHO_W - 1);
      e[b] = ~e[b];
    end
    return e;
  endfunction

  // Offers one tick after a random gap and returns at the falling edge after
  // the transfer. Valid is left high so that back-to-back ticks need no
  // second assignment in the same time step.
  task automatic send_tick(input logic [ECHO_W-1:0] echo, input logic [QIDX_W-1:0] q);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      tick_bus.valid <= 1'b0;
      @(negedge clk);
    end
    tick_bus.valid            <= 1'b1;
    tick_bus.data.echo_lines  <= echo;
    tick_bus.data.query_index <= q;
    do @(posedge clk); while (!(tick_bus.valid && tick_bus.ready));
    @(negedge clk);
  endtask

  // One register write. The caller lowers valid after its last write.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    @(negedge clk);
  endtask

  // Stops the tick stream and waits until every result has been transferred,
  // then idles on to cover the two-stage pipeline.
  task automatic settle();
    tick_bus.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (4) @(negedge clk);
  endtask

  // A scene programs all four registers while the block is idle and then
  // streams ticks with echo pulses drawn from the given spans. Since the
  // sequencer keeps running, a scene switch can land in the middle of a
  // measurement, which is how a lowered sensor count mid-scan gets covered.
  task automatic run_scene(input logic [COUNT_W-1:0] count, input logic [TIME_W-1:0] interval,
                           input logic [TIME_W-1:0] timeout, input logic [MM_W-1:0] limit,
                           input int unsigned low_max, input int unsigned high_max,
                           input int unsigned ticks, input bit quiet, input bit noisy);
    int unsigned k;
    settle();
    write_reg(REG_SENSOR_COUNT, CFG_DATA_W'(count));
    write_reg(REG_READ_INTERVAL, CFG_DATA_W'(interval));
    write_reg(REG_ECHO_TIMEOUT, CFG_DATA_W'(timeout));
    write_reg(REG_BELOW_THRESHOLD, CFG_DATA_W'(limit));
    cfg_bus.valid <= 1'b0;
    low_span  = low_max;
    high_span = high_max;
    glitches  = noisy;
    for (k = 0; k < ticks; k++) begin
      // Redraw the choice between paced and gap-free stretches every 64 ticks.
      if (k % 64 == 0) pace_quiet = quiet || ($urandom_range(0, 3) == 0);
      send_tick(shape_echo(), QIDX_W'($urandom_range(0, 7)));
    end
  endtask

  // The result side draws a stall before each transfer and then holds ready
  // high until the transfer happens.
  initial begin
    int unsigned stall;
    res_bus.ready = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      stall = pick_gap();
      repeat (stall) begin
        res_bus.ready <= 1'b0;
        @(negedge clk);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk); while (!(res_bus.valid && res_bus.ready));
      @(negedge clk);
    end
  end

  initial begin
    int unsigned          k;
    logic [ECHO_W-1:0]    echo;
    logic [TIME_W-1:0]    tmo;

    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = REG_SENSOR_COUNT;
    cfg_bus.data   = '0;
    tick_bus.valid = 1'b0;
    tick_bus.data  = '0;
    pace_quiet     = 1'b0;
    line_level     = '0;
    for (int b = 0; b < ECHO_W; b++) line_left[b] = 0;
    low_span       = 1;
    high_span      = 1;
    glitches       = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening under the reset settings. The first tick starts a
    // measurement at once: two trigger-low ticks, ten trigger-high ticks.
    // All lines sit high during the trigger so the low wait is exercised,
    // then a three-microsecond echo on sensor 0 gives a zero-millimeter
    // reading. The tail alternates the line patterns and every query index
    // is used along the way.
    pace_quiet = ($urandom_range(0, 1) == 0);
    for (k = 0; k < 24; k++) begin
      if (k < 12 || (k >= 13 && k <= 15)) echo = '1;
      else if (k == 12 || k == 16) echo = '0;
      else echo = (k % 2 == 1) ? 8'hAA : 8'h55;
      send_tick(echo, QIDX_W'(k));
    end

    // All eight sensors with glitches enabled and a threshold at its maximum.
    run_scene(4'd8, 16'd1, 16'd3000, 14'd16383, 300, 400, 200, 1'b0, 1'b1);
    // Fewer sensors: the scan wraps early and high queries are out of range.
    run_scene(4'd3, 16'd1, 16'd2000, 14'd40, 200, 300, 150, 1'b0, 1'b1);
    // A count of zero scans one sensor; very short echoes store zero mm.
    run_scene(4'd0, 16'd2, 16'd65535, 14'd0, 50, 6, 150, 1'b0, 1'b1);
    // A count above the sensor total clamps; the short timeout often expires
    // while waiting for the echo.
    run_scene(4'd15, 16'd1, 16'd200, 14'd30, 400, 300, 150, 1'b0, 1'b1);
    // Zero timeout aborts on the first wait tick.
    run_scene(4'd5, 16'd1, 16'd0, 14'd100, 100, 100, 100, 1'b0, 1'b1);
    // Longer echoes on one sensor. Run gap-free and without glitches so
    // that the pulses survive whole.
    run_scene(4'd1, 16'd1, 16'd65535, 14'd16383, 20, 600, 200, 1'b1, 1'b0);

    // Random settings with random echo spans.
    repeat (6) begin
      case ($urandom_range(0, 2))
        0:       tmo = TIME_W'($urandom_range(0, 20));
        1:       tmo = TIME_W'($urandom_range(100, 3000));
        default: tmo = TIME_W'($urandom_range(3000, 65535));
      endcase
      run_scene(COUNT_W'($urandom_range(0, 15)), TIME_W'($urandom_range(1, 3)), tmo,
                ($urandom_range(0, 1) == 0) ? MM_W'($urandom_range(0, 16383))
                                            : MM_W'($urandom_range(0, 120)),
                $urandom_range(1, 400), $urandom_range(1, 700), 80, 1'b0, 1'b1);
    end

    // Longest read interval: no further measurement may start.
    run_scene(4'd8, 16'd65535, 16'd1000, MM_W'($urandom_range(0, 16383)), 100, 100, 100,
              1'b0, 1'b1);

    settle();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== multi_ultrasonic_ranger.f =====
+incdir+rtl/core
rtl/core/mur_pkg.sv
rtl/core/mur_if.sv
rtl/core/mur_sequencer.sv
rtl/core/mur_store.sv
rtl/core/multi_ultrasonic_ranger.sv
rtl/core/mur_checker.sv
tb/ranging_checker.sv
tb/multi_ultrasonic_ranger_tb.sv
